@@ rtl/core/eva_pkg.sv @@
package eva_pkg;

    // Value and progress formats.
    localparam int VALUE_WIDTH   = 32;
    localparam int PROGRESS_BITS = 16;

    // Port and register field widths.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int TIME_W    = 32;
    localparam int MODE_W    = 3;
    localparam int OUT_W     = 32;

    // Progress arithmetic.
    localparam int ONE_W = PROGRESS_BITS + 1;
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << PROGRESS_BITS;

    // Interpolation splits the magnitude of the span into a high and a low part.
    localparam int SPLIT_BITS = 24;
    localparam int MAG_W      = VALUE_WIDTH + 1;
    localparam int HI_W       = (MAG_W > SPLIT_BITS) ? MAG_W - SPLIT_BITS : 1;
    localparam int Q_W        = MAG_W + 1;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = SPLIT_BITS;
    localparam int MUL_B_W = PROGRESS_BITS + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam logic [MUL_B_W-1:0] TWO_ONE = MUL_B_W'(1) << (PROGRESS_BITS + 1);

    // Exponential curve: 2^-x table in Q1.16 with linear interpolation.
    localparam int TAB_W     = 17;
    localparam int TAB_IDX_W = 5;
    localparam int DTAB_W    = 12;
    localparam int FRAC_W    = PROGRESS_BITS - 4;
    localparam int EXPW_W    = TAB_W + FRAC_W;
    localparam int X_W       = PROGRESS_BITS + 4;
    localparam int N_W       = 4;
    localparam int SHAMT_W   = 5;
    localparam logic [SHAMT_W-1:0] EXPO_SHIFT = SHAMT_W'(12);

    // Divider step counter.
    localparam int DIV_CNT_W = $clog2(PROGRESS_BITS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_VALUE = 2'd0,
        CFG_END_VALUE   = 2'd1,
        CFG_DURATION    = 2'd2,
        CFG_EASE_MODE   = 2'd3
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        EASE_LINEAR      = 3'd0,
        EASE_IN_QUAD     = 3'd1,
        EASE_OUT_QUAD    = 3'd2,
        EASE_IN_OUT_QUAD = 3'd3,
        EASE_OUT_CUBIC   = 3'd4,
        EASE_OUT_EXPO    = 3'd5
    } t_ease;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                          start;
        t_ease                         mode;
        logic [PROGRESS_BITS-1:0]      t;
        logic signed [VALUE_WIDTH:0]   diff;
        logic signed [VALUE_WIDTH-1:0] base;
    } t_curve_req;

    // 2^(-k/16) in Q1.16 for k = 0 .. 16.
    function automatic logic [TAB_W-1:0] exp_tab(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60096;
            5'd3:    v = 17'd57548;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/eva_item_if.sv @@
interface eva_item_if;
    import eva_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, kind, now_ms, input ready);
    modport sink (input valid, kind, now_ms, output ready);
endinterface

@@ rtl/core/eva_result_if.sv @@
interface eva_result_if;
    import eva_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] current_value;
    logic                    is_active;
    logic                    is_finished;

    modport source (output valid, current_value, is_active, is_finished, input ready);
    modport sink (input valid, current_value, is_active, is_finished, output ready);
endinterface

@@ rtl/core/eva_div.sv @@
module eva_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  eva_pkg::t_div_req                   i_req,
    output logic                                o_done,
    output logic [eva_pkg::PROGRESS_BITS-1:0]   o_quot
);
    import eva_pkg::*;

    // Restoring division, one quotient bit per cycle. The dividend is the
    // elapsed time scaled by 2^PROGRESS_BITS, and since elapsed is below the
    // divisor the partial remainder starts as elapsed itself.
    logic [TIME_W-1:0]        r_rem;
    logic [TIME_W-1:0]        r_div;
    logic [PROGRESS_BITS-1:0] r_quot;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [TIME_W:0] shifted;
    logic [TIME_W:0] trial;
    logic            fits;

    always_comb begin
        shifted = {r_rem, 1'b0};
        fits    = shifted >= {1'b0, r_div};
        trial   = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_cnt  <= DIV_CNT_W'(PROGRESS_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? TIME_W'(trial) : TIME_W'(shifted);
                r_quot <= {r_quot[PROGRESS_BITS-2:0], fits};
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/core/eva_curve.sv @@
module eva_curve (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  eva_pkg::t_curve_req                      i_req,
    output logic                                     o_done,
    output logic signed [eva_pkg::VALUE_WIDTH-1:0]   o_value
);
    import eva_pkg::*;

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_E1   = 7'b0000010,
        C_E2   = 7'b0000100,
        C_E3   = 7'b0001000,
        C_HI   = 7'b0010000,
        C_LO   = 7'b0100000,
        C_FIN  = 7'b1000000
    } t_cstate;

    t_cstate r_state;

    t_ease                         r_mode;
    logic [PROGRESS_BITS-1:0]      r_t;
    logic                          r_neg;
    logic [MAG_W-1:0]              r_mag;
    logic signed [VALUE_WIDTH-1:0] r_base;
    logic [N_W-1:0]                r_n;
    logic [FRAC_W-1:0]             r_rem;
    logic [TAB_W-1:0]              r_tab_lo;
    logic [DTAB_W-1:0]             r_dtab;
    logic [PROD_W-1:0]             r_prod;
    logic [PROD_W-1:0]             r_hi_prod;
    logic [ONE_W-1:0]              r_e;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic                          r_done;

    // Operand preparation at request time: the exponential curve's table lookup and the span magnitude.
    logic [X_W-1:0]       x;
    logic [3:0]           tab_idx;
    logic [TAB_W-1:0]     tab_lo;
    logic [TAB_W-1:0]     tab_hi;
    logic [MAG_W-1:0]     mag_in;

    always_comb begin
        x       = (X_W'(i_req.t) << 3) + (X_W'(i_req.t) << 1);
        tab_idx = x[PROGRESS_BITS-1 -: 4];
        tab_lo  = exp_tab({1'b0, tab_idx});
        tab_hi  = exp_tab(TAB_IDX_W'({1'b0, tab_idx}) + TAB_IDX_W'(1));
        mag_in  = i_req.diff[VALUE_WIDTH] ? MAG_W'(-i_req.diff) : MAG_W'(i_req.diff);
    end

    // Shared multiplier, product registered every cycle.
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [ONE_W-1:0]   f;
    logic [PROD_W-1:0]  n_prod;

    always_comb begin
        f     = ONE - ONE_W'(r_t);
        mul_a = '0;
        mul_b = '0;
        unique case (r_state) inside
            C_E1: begin
                case (r_mode)
                    EASE_IN_QUAD: begin
                        mul_a = MUL_A_W'(r_t);
                        mul_b = MUL_B_W'(r_t);
                    end
                    EASE_OUT_QUAD: begin
                        mul_a = MUL_A_W'(r_t);
                        mul_b = TWO_ONE - MUL_B_W'(r_t);
                    end
                    EASE_IN_OUT_QUAD: begin
                        if (r_t[PROGRESS_BITS-1]) begin
                            mul_a = MUL_A_W'(f);
                            mul_b = MUL_B_W'(f);
                        end else begin
                            mul_a = MUL_A_W'(r_t);
                            mul_b = MUL_B_W'(r_t);
                        end
                    end
                    EASE_OUT_CUBIC: begin
                        mul_a = MUL_A_W'(f);
                        mul_b = MUL_B_W'(f);
                    end
                    EASE_OUT_EXPO: begin
                        mul_a = MUL_A_W'(r_dtab);
                        mul_b = MUL_B_W'(r_rem);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            C_E2: begin
                mul_a = MUL_A_W'(r_prod >> PROGRESS_BITS);
                mul_b = MUL_B_W'(f);
            end
            C_HI: begin
                mul_a = MUL_A_W'(r_mag >> SPLIT_BITS);
                mul_b = MUL_B_W'(r_e);
            end
            C_LO: begin
                mul_a = MUL_A_W'(r_mag[SPLIT_BITS-1:0]);
                mul_b = MUL_B_W'(r_e);
            end
            C_IDLE, C_E3, C_FIN: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Curve value from the first product, or the progress itself for the linear curve.
    logic [EXPW_W-1:0] expo_w;
    logic [EXPW_W-1:0] expo_sh;
    logic [ONE_W-1:0]  e_first;

    always_comb begin
        expo_w  = {r_tab_lo, {FRAC_W{1'b0}}} - EXPW_W'(r_prod);
        expo_sh = expo_w >> ({1'b0, r_n} + EXPO_SHIFT);
        case (r_mode) inside
            EASE_IN_QUAD, EASE_OUT_QUAD: begin
                e_first = ONE_W'(r_prod >> PROGRESS_BITS);
            end
            EASE_IN_OUT_QUAD: begin
                if (r_t[PROGRESS_BITS-1]) begin
                    e_first = ONE - ONE_W'(r_prod >> (PROGRESS_BITS - 1));
                end else begin
                    e_first = ONE_W'(r_prod >> (PROGRESS_BITS - 1));
                end
            end
            EASE_OUT_EXPO: begin
                e_first = ONE - ONE_W'(expo_sh);
            end
            default: begin
                e_first = ONE_W'(r_t);
            end
        endcase
    end

    // Final interpolation step.
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] base_ext;
    logic [Q_W-1:0] sum;

    always_comb begin
        q        = (Q_W'(r_hi_prod) << (SPLIT_BITS - PROGRESS_BITS))
                 + Q_W'(r_prod >> PROGRESS_BITS);
        base_ext = {{(Q_W - VALUE_WIDTH){r_base[VALUE_WIDTH-1]}}, r_base};
        sum      = r_neg ? base_ext - q : base_ext + q;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_mode   <= i_req.mode;
                        r_t      <= i_req.t;
                        r_neg    <= i_req.diff[VALUE_WIDTH];
                        r_mag    <= mag_in;
                        r_base   <= i_req.base;
                        r_n      <= x[X_W-1:PROGRESS_BITS];
                        r_rem    <= x[FRAC_W-1:0];
                        r_tab_lo <= tab_lo;
                        r_dtab   <= DTAB_W'(tab_lo - tab_hi);
                        r_state  <= C_E1;
                    end
                end
                C_E1: begin
                    r_state <= C_E2;
                end
                C_E2: begin
                    if (r_mode == EASE_OUT_CUBIC) begin
                        r_state <= C_E3;
                    end else begin
                        r_e     <= e_first;
                        r_state <= C_HI;
                    end
                end
                C_E3: begin
                    r_e     <= ONE - ONE_W'(r_prod >> PROGRESS_BITS);
                    r_state <= C_HI;
                end
                C_HI: begin
                    r_state <= C_LO;
                end
                C_LO: begin
                    r_hi_prod <= r_prod;
                    r_state   <= C_FIN;
                end
                C_FIN: begin
                    r_value <= VALUE_WIDTH'(sum);
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

@@ rtl/core/eased_value_animator.sv @@
// Eased value animator. Configuration (start value, end value, duration in
// milliseconds and ease mode) is written through a plain write port; the user
// must write it only while the block is idle, which the block itself does not
// enforce. A start item latches that configuration together with its
// timestamp and reports the start value; an update item reports the eased
// value for its timestamp, and the end value once the duration has elapsed.
// Every accepted input beat produces exactly one result beat carrying the
// present value in signed Q16.16 and the running and finished flags. Start
// items, updates on an idle or finished animation and the update that ends an
// animation go straight to the emit state, from which their result moves into
// the output register. An update in the middle of an animation passes through
// the 16-step bit-serial divider that forms the progress, then the five steps
// of the curve unit (six for out-cubic), in which the shared multiplier serves
// the curve where it needs one and then the high and low parts of the
// interpolation, and then the emit state. A result that still waits in the
// output register delays the next one by the length of that wait. The input
// is not ready while an item is in work, but a new item is accepted while an
// earlier result still waits in the output register.
module eased_value_animator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [eva_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [eva_pkg::CFG_W-1:0]          i_cfg_data,
    eva_item_if.sink                           i_item,
    eva_result_if.source                       o_result
);
    import eva_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_DIV   = 4'b0010,
        T_CURVE = 4'b0100,
        T_EMIT  = 4'b1000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [CFG_W-1:0]  r_cfg_start;
    logic [CFG_W-1:0]  r_cfg_end;
    logic [TIME_W-1:0] r_cfg_duration;
    logic [MODE_W-1:0] r_cfg_mode;

    // Animation state captured by a start item.
    logic signed [VALUE_WIDTH-1:0] r_from;
    logic signed [VALUE_WIDTH-1:0] r_to;
    logic signed [VALUE_WIDTH:0]   r_diff;
    logic [TIME_W-1:0]             r_len;
    logic [MODE_W-1:0]             r_curve;
    logic [TIME_W-1:0]             r_began;
    logic signed [VALUE_WIDTH-1:0] r_present;
    logic                          r_running;
    logic                          r_done;

    // Output register.
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_value;
    logic                    r_out_active;
    logic                    r_out_finished;

    logic signed [VALUE_WIDTH-1:0] cfg_from;
    logic signed [VALUE_WIDTH-1:0] cfg_to;
    logic [TIME_W-1:0]             elapsed;
    logic                          reached_end;
    logic                          accept;
    logic                          in_flight;
    logic                          emit;

    t_div_req                 div_req;
    logic                     div_done;
    logic [PROGRESS_BITS-1:0] div_quot;
    t_curve_req               curve_req;
    logic                     curve_done;
    logic signed [VALUE_WIDTH-1:0] curve_value;

    always_comb begin
        cfg_from    = VALUE_WIDTH'(signed'(r_cfg_start));
        cfg_to      = VALUE_WIDTH'(signed'(r_cfg_end));
        elapsed     = i_item.now_ms - r_began;
        reached_end = elapsed >= r_len;
        accept      = i_item.valid && (r_state == T_IDLE);
        // An update on a running animation that has not reached its end
        // needs the divider and the curve unit.
        in_flight   = accept && !i_item.kind && r_running && !r_done && !reached_end;
        // The result moves into the output register once that register is
        // empty or is being emptied in the same cycle.
        emit        = (r_state == T_EMIT) && (!r_out_valid || o_result.ready);

        div_req.start    = in_flight;
        div_req.dividend = elapsed;
        div_req.divisor  = r_len;

        curve_req.start = (r_state == T_DIV) && div_done;
        curve_req.mode  = t_ease'(r_curve);
        curve_req.t     = div_quot;
        curve_req.diff  = r_diff;
        curve_req.base  = r_from;
    end

    eva_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    eva_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (curve_req),
        .o_done  (curve_done),
        .o_value (curve_value)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start    <= '0;
            r_cfg_end      <= '0;
            r_cfg_duration <= '0;
            r_cfg_mode     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_START_VALUE: r_cfg_start    <= i_cfg_data;
                CFG_END_VALUE:   r_cfg_end      <= i_cfg_data;
                CFG_DURATION:    r_cfg_duration <= TIME_W'(i_cfg_data);
                CFG_EASE_MODE:   r_cfg_mode     <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and animation state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_from      <= '0;
            r_to        <= '0;
            r_diff      <= '0;
            r_len       <= '0;
            r_curve     <= '0;
            r_began     <= '0;
            r_present   <= '0;
            r_running   <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        if (i_item.kind) begin
                            r_from    <= cfg_from;
                            r_to      <= cfg_to;
                            r_diff    <= (VALUE_WIDTH + 1)'(cfg_to)
                                       - (VALUE_WIDTH + 1)'(cfg_from);
                            r_len     <= r_cfg_duration;
                            r_curve   <= r_cfg_mode;
                            r_began   <= i_item.now_ms;
                            r_present <= cfg_from;
                            r_running <= 1'b1;
                            r_done    <= 1'b0;
                            r_state   <= T_EMIT;
                        end else if (in_flight) begin
                            r_state <= T_DIV;
                        end else begin
                            if (r_running && !r_done) begin
                                // The duration has run out.
                                r_present <= r_to;
                                r_running <= 1'b0;
                                r_done    <= 1'b1;
                            end
                            r_state <= T_EMIT;
                        end
                    end
                end
                T_DIV: begin
                    if (div_done) begin
                        r_state <= T_CURVE;
                    end
                end
                T_CURVE: begin
                    if (curve_done) begin
                        r_present <= curve_value;
                        r_state   <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (emit) begin
                        r_out_value    <= OUT_W'(r_present);
                        r_out_active   <= r_running;
                        r_out_finished <= r_done;
                        r_state        <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready           = (r_state == T_IDLE);
    assign o_result.valid         = r_out_valid;
    assign o_result.current_value = r_out_value;
    assign o_result.is_active     = r_out_active;
    assign o_result.is_finished   = r_out_finished;

endmodule
